FILE: hw/rtl/cffa_pkg.sv
// Shared constants of the circular first-fit allocator: status codes and default sizes.
`default_nettype none

package cffa_pkg;

  // Default arena size in words (header words included)
  localparam int unsigned ArenaWordsDefault = 1024;

  // Fixed field widths of the transaction ports
  localparam int unsigned SizeW   = 10;
  localparam int unsigned AddrW   = 10;
  localparam int unsigned StatusW = 3;

  typedef logic [StatusW-1:0] status_t;

  // Result status codes
  localparam status_t StOk      = 3'd0;
  localparam status_t StNoRoom  = 3'd1;
  localparam status_t StRange   = 3'd2;
  localparam status_t StBadFree = 3'd3;
  localparam status_t StCorrupt = 3'd4;

  // Request opcodes
  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

endpackage

`default_nettype wire

FILE: hw/rtl/cffa_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
`default_nettype none

module cffa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write, and read the old contents on a same-address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/circular_first_fit_allocator_core.sv
// Circular first-fit arena allocator: header ring in RAM, walk/merge/split sequencer.
// Free: reads the header, then writes it back with the busy bit clear; out of range is answered from idle.
// Allocate: passes each busy header, merges the free successors into each free header and checks
//   the fit, splits off a remainder when there is one, then strobes (one RAM read per step).
// One transaction at a time; busy stays high from accept until the result strobe, unless answered from idle.
// After reset an init pass writes all ARENA_WORDS headers (busy high).
// Results appear for one cycle with done_o; the receiver cannot stall.
`default_nettype none

module circular_first_fit_allocator_core #(
  parameter int unsigned ARENA_WORDS = cffa_pkg::ArenaWordsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         op_i,
  input  wire logic [cffa_pkg::SizeW-1:0]   size_words_i,
  input  wire logic [cffa_pkg::AddrW-1:0]   block_addr_i,
  output logic                              done_o,
  output cffa_pkg::status_t                 status_o,
  output logic [cffa_pkg::AddrW-1:0]        data_addr_o
);

  localparam int unsigned AW  = $clog2(ARENA_WORDS);
  localparam int unsigned EW  = AW + 1;                       // {link, busy}
  localparam int unsigned NW  = cffa_pkg::SizeW + 1;          // need = size + 1
  localparam int unsigned CW  = ((AW > NW) ? AW : NW) + 1;    // fit arithmetic
  localparam int unsigned PW  = ((AW + 1) > cffa_pkg::AddrW) ? (AW + 1) : cffa_pkg::AddrW;
  localparam int unsigned MW  = AW + 2;                       // merge run counter
  localparam int unsigned GW  = AW + 3;                       // walk step counter
  localparam int unsigned BW  = ((AW + 1) > cffa_pkg::AddrW) ? (AW + 1) : (cffa_pkg::AddrW + 1);

  localparam logic [AW-1:0] TopWord  = AW'(ARENA_WORDS - 1);
  localparam logic [AW:0]   WordsLim = (AW + 1)'(ARENA_WORDS);
  localparam logic [MW-1:0] MergeLim = MW'(ARENA_WORDS);
  localparam logic [GW-1:0] GuardLim = GW'(2 * ARENA_WORDS + 4);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_FREE  = 6'b000100,
    S_HDR   = 6'b001000,
    S_MERGE = 6'b010000,
    S_MARK  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     init_cnt_q, init_cnt_d;
  logic [AW-1:0]     rover_q, rover_d;
  logic [AW-1:0]     p_q, p_d;
  logic [AW-1:0]     plink_q, plink_d;
  logic [AW-1:0]     split_q, split_d;
  logic [NW-1:0]     need_q, need_d;
  logic [MW-1:0]     merge_q, merge_d;
  logic [GW-1:0]     guard_q, guard_d;
  logic              wrapped_q, wrapped_d;
  logic              done_q, done_d;
  cffa_pkg::status_t status_q, status_d;
  logic [cffa_pkg::AddrW-1:0] data_addr_q, data_addr_d;

  // RAM port signals and same-address forwarding
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [EW-1:0]     ram_wdata, ram_rdata, rd_entry;
  logic              fwd_hit_q;
  logic [EW-1:0]     fwd_data_q;

  cffa_ram #(
    .Width (EW),
    .Depth (ARENA_WORDS)
  ) u_links (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = fwd_hit_q ? fwd_data_q : ram_rdata;

  // Decode the header just read
  logic [AW-1:0] rd_link;
  logic          rd_busy;
  assign rd_link = rd_entry[EW-1:1];
  assign rd_busy = rd_entry[0];

  // Fit check against the current merged hole [p, plink)
  logic [CW-1:0] hole_w, split_w;
  logic          fit, split_rem;
  assign hole_w    = CW'(plink_q) - CW'(p_q);
  assign split_w   = CW'(p_q) + CW'(need_q);
  assign fit       = (plink_q > p_q) && (hole_w >= CW'(need_q));
  assign split_rem = CW'(plink_q) > split_w;

  logic [PW-1:0] first_data;
  assign first_data = PW'(p_q) + PW'(1);

  // Step to the next header of the ring
  logic [AW-1:0] adv_next;
  logic          adv_bad, adv_back, adv_guard;
  logic [GW-1:0] guard_inc;
  assign adv_next  = (state_q == S_HDR) ? rd_link : plink_q;
  assign adv_bad   = ({1'b0, adv_next} >= WordsLim) || (adv_next == p_q);
  assign adv_back  = adv_next < p_q;
  assign guard_inc = guard_q + GW'(1);
  assign adv_guard = guard_inc > GuardLim;

  // Free request range check and header address
  logic [BW-1:0] baddr_w;
  logic          free_range_ok;
  assign baddr_w       = BW'(block_addr_i);
  assign free_range_ok = (baddr_w >= BW'(1)) && (baddr_w < BW'(TopWord));

  logic take_adv;

  always_comb begin
    state_d     = state_q;
    init_cnt_d  = init_cnt_q;
    rover_d     = rover_q;
    p_d         = p_q;
    plink_d     = plink_q;
    split_d     = split_q;
    need_d      = need_q;
    merge_d     = merge_q;
    guard_d     = guard_q;
    wrapped_d   = wrapped_q;
    done_d      = 1'b0;
    status_d    = status_q;
    data_addr_d = data_addr_q;
    ram_we      = 1'b0;
    ram_waddr   = p_q;
    ram_wdata   = '0;
    ram_raddr   = p_q;
    take_adv    = 1'b0;

    unique case (state_q)
      // Write the reset ring: word 0 free to top, top busy to 0, rest zero
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = init_cnt_q;
        if (init_cnt_q == '0) begin
          ram_wdata = {TopWord, 1'b0};
        end else if (init_cnt_q == TopWord) begin
          ram_wdata = {{AW{1'b0}}, 1'b1};
        end
        init_cnt_d = init_cnt_q + AW'(1);
        if (init_cnt_q == TopWord) begin
          state_d = S_IDLE;
        end
      end

      // Take a transaction
      S_IDLE: begin
        if (start) begin
          if (op_i == cffa_pkg::OpFree) begin
            if (free_range_ok) begin
              p_d       = AW'(baddr_w - BW'(1));
              ram_raddr = AW'(baddr_w - BW'(1));
              state_d   = S_FREE;
            end else begin
              done_d      = 1'b1;
              status_d    = cffa_pkg::StRange;
              data_addr_d = '0;
            end
          end else begin
            need_d    = NW'(size_words_i) + NW'(1);
            p_d       = rover_q;
            ram_raddr = rover_q;
            guard_d   = '0;
            wrapped_d = 1'b0;
            if ({1'b0, rover_q} >= WordsLim) begin
              done_d      = 1'b1;
              status_d    = cffa_pkg::StCorrupt;
              data_addr_d = '0;
            end else begin
              state_d = S_HDR;
            end
          end
        end
      end

      // Clear the busy bit, flag a self link
      S_FREE: begin
        ram_we      = 1'b1;
        ram_waddr   = p_q;
        ram_wdata   = {rd_link, 1'b0};
        done_d      = 1'b1;
        data_addr_d = '0;
        status_d    = (rd_link == p_q) ? cffa_pkg::StBadFree : cffa_pkg::StOk;
        state_d     = S_IDLE;
      end

      // Busy header: move on; free header: fetch its successor to merge, or report corrupt on a bad link
      S_HDR: begin
        if (rd_busy) begin
          take_adv = 1'b1;
        end else if ({1'b0, rd_link} >= WordsLim) begin
          done_d      = 1'b1;
          status_d    = cffa_pkg::StCorrupt;
          data_addr_d = '0;
          state_d     = S_IDLE;
        end else begin
          plink_d   = rd_link;
          ram_raddr = rd_link;
          merge_d   = '0;
          state_d   = S_MERGE;
        end
      end

      // Absorb free successors, then try the hole, moving on if it does not fit
      S_MERGE: begin
        if (!rd_busy) begin
          if (merge_q + MW'(1) > MergeLim) begin
            done_d      = 1'b1;
            status_d    = cffa_pkg::StCorrupt;
            data_addr_d = '0;
            state_d     = S_IDLE;
          end else begin
            merge_d   = merge_q + MW'(1);
            ram_we    = 1'b1;
            ram_waddr = p_q;
            ram_wdata = {rd_link, 1'b0};
            plink_d   = rd_link;
            ram_raddr = rd_link;
            if ({1'b0, rd_link} >= WordsLim) begin
              done_d      = 1'b1;
              status_d    = cffa_pkg::StCorrupt;
              data_addr_d = '0;
              state_d     = S_IDLE;
            end
          end
        end else if (fit) begin
          split_d = AW'(split_w);
          if (split_rem) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(split_w);
            ram_wdata = {plink_q, 1'b0};
            state_d   = S_MARK;
          end else begin
            ram_we      = 1'b1;
            ram_waddr   = p_q;
            ram_wdata   = {AW'(split_w), 1'b1};
            rover_d     = AW'(split_w);
            done_d      = 1'b1;
            status_d    = cffa_pkg::StOk;
            data_addr_d = first_data[cffa_pkg::AddrW-1:0];
            state_d     = S_IDLE;
          end
        end else begin
          take_adv = 1'b1;
        end
      end

      // Mark the allocated block busy after the split
      S_MARK: begin
        ram_we      = 1'b1;
        ram_waddr   = p_q;
        ram_wdata   = {split_q, 1'b1};
        rover_d     = split_q;
        done_d      = 1'b1;
        status_d    = cffa_pkg::StOk;
        data_addr_d = first_data[cffa_pkg::AddrW-1:0];
        state_d     = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Advance the walk: corrupt link, second wrap, or step limit ends it
    if (take_adv) begin
      if (adv_bad) begin
        done_d      = 1'b1;
        status_d    = cffa_pkg::StCorrupt;
        data_addr_d = '0;
        state_d     = S_IDLE;
      end else if (adv_back && wrapped_q) begin
        rover_d     = TopWord;
        done_d      = 1'b1;
        status_d    = cffa_pkg::StNoRoom;
        data_addr_d = '0;
        state_d     = S_IDLE;
      end else if (adv_guard) begin
        done_d      = 1'b1;
        status_d    = cffa_pkg::StCorrupt;
        data_addr_d = '0;
        state_d     = S_IDLE;
      end else begin
        wrapped_d = wrapped_q | adv_back;
        guard_d   = guard_inc;
        p_d       = adv_next;
        ram_raddr = adv_next;
        state_d   = S_HDR;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      init_cnt_q <= '0;
      rover_q    <= '0;
      done_q     <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      init_cnt_q <= init_cnt_d;
      rover_q    <= rover_d;
      done_q     <= done_d;
      fwd_hit_q  <= ram_we && (ram_waddr == ram_raddr);
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    p_q         <= p_d;
    plink_q     <= plink_d;
    split_q     <= split_d;
    need_q      <= need_d;
    merge_q     <= merge_d;
    guard_q     <= guard_d;
    wrapped_q   <= wrapped_d;
    status_q    <= status_d;
    data_addr_q <= data_addr_d;
    fwd_data_q  <= ram_wdata;
  end

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign data_addr_o = data_addr_q;

endmodule

`default_nettype wire
